/* rtl/core/multilabel_confusion_accumulate_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the confusion accumulator
// Same-cycle and next-cycle implication checks on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MULTILABEL_CONFUSION_ACCUMULATE_ASSERT_SVH
`define MULTILABEL_CONFUSION_ACCUMULATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MLCA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MLCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mlca_pkg.sv */
// ----------------------------------------------------------------------------
// mlca_pkg
// Shared widths, codes, command type and helpers of the confusion accumulator.
// ----------------------------------------------------------------------------
package mlca_pkg;

  localparam int MAX_CLASSES_DEF = 16;
  localparam int MASK_W   = 16;
  localparam int WEIGHT_W = 24;
  localparam int ENTRY_W  = 56;
  localparam int FRAC_W   = 16;
  localparam int WQ_W     = WEIGHT_W + FRAC_W;
  localparam int CNT_W    = 5;
  localparam int DVD_W    = WQ_W + CNT_W;
  localparam int ACLS_W   = 5;
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 4;
  localparam int PADDR_W  = 2;
  localparam int PDATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W   = 1;
  localparam int QCNT_W   = 2;

  localparam logic [FUNC_W-1:0] FUNC_ACC   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  localparam logic [PADDR_W-1:0] REG_ACTIVE_CLASSES = 2'd0;
  localparam logic [ACLS_W-1:0]  ACTIVE_CLASSES_RST = 5'd16;

  typedef enum logic [1:0] {
    OP_ACC,
    OP_READ,
    OP_CLEAR
  } op_t;

  // One classified transaction handed from the front to the back
  typedef struct packed {
    op_t                 op;
    logic [MASK_W-1:0]   diag_rows;
    logic [MASK_W-1:0]   blk_rows;
    logic [MASK_W-1:0]   blk_cols;
    logic                need_div;
    logic                diag_div;
    logic [WEIGHT_W-1:0] weight;
    logic [CNT_W-1:0]    gt_cnt;
    logic [CNT_W-1:0]    divisor;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic div_wait;
  } back_stat_t;

  function automatic logic [CNT_W-1:0] popcount16(input logic [MASK_W-1:0] m);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int k = 0; k < MASK_W; k++) begin
      n = n + CNT_W'(m[k]);
    end
    return n;
  endfunction

endpackage

/* rtl/core/mlca_front.sv */
// ----------------------------------------------------------------------------
// mlca_front
// Configuration register and classifier: masks the class sets and picks the
// multi-label case for each accepted transaction.
// ----------------------------------------------------------------------------
module mlca_front #(
  parameter int MAX_CLASSES = mlca_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mlca_pkg::PADDR_W-1:0]       paddr,
  input  logic [mlca_pkg::PDATA_W-1:0]       pwdata,
  output logic [mlca_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready,
  input  logic                               accept,
  input  logic [mlca_pkg::FUNC_W-1:0]        in_func,
  input  logic [mlca_pkg::MASK_W-1:0]        in_gt_mask,
  input  logic [mlca_pkg::MASK_W-1:0]        in_pred_mask,
  input  logic [mlca_pkg::WEIGHT_W-1:0]      in_weight,
  input  logic [mlca_pkg::IDX_W-1:0]         in_row_index,
  input  logic [mlca_pkg::IDX_W-1:0]         in_col_index,
  output logic                               cmd_valid,
  output mlca_pkg::cmd_t                     cmd
);

  localparam int NCE = (MAX_CLASSES < mlca_pkg::MASK_W) ? MAX_CLASSES : mlca_pkg::MASK_W;

  logic [mlca_pkg::ACLS_W-1:0] active_classes_r;
  logic [mlca_pkg::ACLS_W-1:0] nc;
  logic [mlca_pkg::MASK_W-1:0] keep;
  logic [mlca_pkg::MASK_W-1:0] g;
  logic [mlca_pkg::MASK_W-1:0] p;
  logic [mlca_pkg::MASK_W-1:0] pd;
  logic [mlca_pkg::CNT_W-1:0]  cnt_p;
  logic [mlca_pkg::CNT_W-1:0]  cnt_pd;

  // Write the class count on a completed write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_classes_r <= mlca_pkg::ACTIVE_CLASSES_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr == mlca_pkg::REG_ACTIVE_CLASSES) begin
      active_classes_r <= pwdata[mlca_pkg::ACLS_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == mlca_pkg::REG_ACTIVE_CLASSES) ?
                  mlca_pkg::PDATA_W'(active_classes_r) : '0;

  // Cap the class count and drop mask bits beyond it
  assign nc = (active_classes_r > mlca_pkg::ACLS_W'(NCE)) ?
              mlca_pkg::ACLS_W'(NCE) : active_classes_r;

  always_comb begin
    for (int k = 0; k < mlca_pkg::MASK_W; k++) begin
      keep[k] = (mlca_pkg::ACLS_W'(k) < nc);
    end
  end

  assign g      = in_gt_mask & keep;
  assign p      = in_pred_mask & keep;
  assign pd     = p & ~g;
  assign cnt_p  = mlca_pkg::popcount16(p);
  assign cnt_pd = mlca_pkg::popcount16(pd);

  // Classify the transaction
  always_comb begin
    cmd           = '0;
    cmd.weight    = in_weight;
    cmd.gt_cnt    = mlca_pkg::popcount16(g);
    cmd.row       = in_row_index;
    cmd.col       = in_col_index;
    cmd_valid     = accept;
    unique case (in_func)
      mlca_pkg::FUNC_ACC: begin
        cmd.op = mlca_pkg::OP_ACC;
        priority if (g == p) begin
          cmd.diag_rows = g;
        end else if ((g & p) == g) begin
          cmd.diag_rows = g;
          cmd.diag_div  = 1'b1;
          cmd.blk_rows  = g;
          cmd.blk_cols  = pd;
          cmd.divisor   = cnt_p;
          cmd.need_div  = 1'b1;
        end else if ((g | p) == g) begin
          cmd.diag_rows = p;
          cmd.blk_rows  = g & ~p;
          cmd.blk_cols  = (cnt_p != '0) ? p : '0;
          cmd.divisor   = cnt_p;
          cmd.need_div  = (cnt_p != '0);
        end else begin
          cmd.diag_rows = g & p;
          cmd.blk_rows  = g & ~p;
          cmd.blk_cols  = (cnt_pd != '0) ? pd : '0;
          cmd.divisor   = cnt_pd;
          cmd.need_div  = (cnt_pd != '0);
        end
      end
      mlca_pkg::FUNC_READ:  cmd.op = mlca_pkg::OP_READ;
      mlca_pkg::FUNC_CLEAR: cmd.op = mlca_pkg::OP_CLEAR;
      default:              cmd_valid = 1'b0;
    endcase
  end

endmodule

/* rtl/core/mlca_queue.sv */
// ----------------------------------------------------------------------------
// mlca_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module mlca_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  mlca_pkg::cmd_t                push_cmd,
  input  logic                          pop,
  output logic                          q_valid,
  output mlca_pkg::cmd_t                head_cmd,
  output logic                          full,
  output logic [mlca_pkg::QCNT_W-1:0]   count
);

  mlca_pkg::cmd_t                entry_r [mlca_pkg::QUEUE_DEPTH];
  logic [mlca_pkg::QPTR_W-1:0]   wptr_r;
  logic [mlca_pkg::QPTR_W-1:0]   rptr_r;
  logic [mlca_pkg::QCNT_W-1:0]   count_r;

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      count_r <= count_r + mlca_pkg::QCNT_W'(push) - mlca_pkg::QCNT_W'(pop);
    end
  end

  assign q_valid  = (count_r != '0);
  assign full     = (count_r == mlca_pkg::QCNT_W'(mlca_pkg::QUEUE_DEPTH));
  assign head_cmd = entry_r[rptr_r];
  assign count    = count_r;

endmodule

/* rtl/core/mlca_div.sv */
// ----------------------------------------------------------------------------
// mlca_div
// Bit-serial restoring divider: two dividends over one small divisor.
// ----------------------------------------------------------------------------
module mlca_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [mlca_pkg::DVD_W-1:0]   dvd_a,
  input  logic [mlca_pkg::DVD_W-1:0]   dvd_b,
  input  logic [mlca_pkg::CNT_W-1:0]   dvs,
  output logic                         done,
  output logic [mlca_pkg::DVD_W-1:0]   quo_a,
  output logic [mlca_pkg::DVD_W-1:0]   quo_b
);

  localparam int STEP_W = $clog2(mlca_pkg::DVD_W + 1);

  logic [mlca_pkg::DVD_W-1:0] qa_r;
  logic [mlca_pkg::DVD_W-1:0] qb_r;
  logic [mlca_pkg::CNT_W-1:0] ra_r;
  logic [mlca_pkg::CNT_W-1:0] rb_r;
  logic [mlca_pkg::CNT_W-1:0] dvs_r;
  logic [STEP_W-1:0]          step_r;
  logic                       busy_r;
  logic                       done_r;
  logic [mlca_pkg::CNT_W:0]   ra_sh;
  logic [mlca_pkg::CNT_W:0]   rb_sh;
  logic                       ga;
  logic                       gb;

  assign ra_sh = {ra_r, qa_r[mlca_pkg::DVD_W-1]};
  assign rb_sh = {rb_r, qb_r[mlca_pkg::DVD_W-1]};
  assign ga    = (ra_sh >= {1'b0, dvs_r});
  assign gb    = (rb_sh >= {1'b0, dvs_r});

  // Shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        qa_r   <= dvd_a;
        qb_r   <= dvd_b;
        ra_r   <= '0;
        rb_r   <= '0;
        dvs_r  <= dvs;
      end else if (busy_r) begin
        qa_r <= {qa_r[mlca_pkg::DVD_W-2:0], ga};
        qb_r <= {qb_r[mlca_pkg::DVD_W-2:0], gb};
        ra_r <= ga ? mlca_pkg::CNT_W'(ra_sh - {1'b0, dvs_r}) : mlca_pkg::CNT_W'(ra_sh);
        rb_r <= gb ? mlca_pkg::CNT_W'(rb_sh - {1'b0, dvs_r}) : mlca_pkg::CNT_W'(rb_sh);
        if (step_r == STEP_W'(mlca_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign quo_a = qa_r;
  assign quo_b = qb_r;

endmodule

/* rtl/core/mlca_back.sv */
// ----------------------------------------------------------------------------
// mlca_back
// Executes queued commands: divides the weight when the case needs it, then sweeps
// the matrix rows with a row-wide read-modify-write; serves reads and clears.
// ----------------------------------------------------------------------------
module mlca_back #(
  parameter int MAX_CLASSES = mlca_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  mlca_pkg::cmd_t                    head_cmd,
  output logic                              q_pop,
  output logic                              out_valid,
  output logic [mlca_pkg::ENTRY_W-1:0]      out_entry_value,
  output mlca_pkg::back_stat_t              stat
);

  localparam int NCE   = (MAX_CLASSES < mlca_pkg::MASK_W) ? MAX_CLASSES : mlca_pkg::MASK_W;
  localparam int ROW_W = (NCE > 1) ? $clog2(NCE) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_RD,
    S_WR,
    S_OUT
  } state_t;

  typedef logic [NCE-1:0][mlca_pkg::ENTRY_W-1:0] row_t;

  state_t                         state_r;
  mlca_pkg::cmd_t                 cmd_r;
  logic [ROW_W-1:0]               row_r;
  logic [NCE-1:0]                 row_valid_r;
  logic [mlca_pkg::DVD_W-1:0]     damt_r;
  logic [mlca_pkg::DVD_W-1:0]     bamt_r;
  logic                           rvalid_r;
  logic                           in_range_r;
  logic                           out_valid_r;
  logic [mlca_pkg::ENTRY_W-1:0]   out_value_r;
  row_t                           mem [NCE];
  row_t                           rdata_r;
  row_t                           wdata;
  logic                           mem_re;
  logic [ROW_W-1:0]               mem_raddr;
  logic                           mem_we;
  logic                           div_start;
  logic                           div_done;
  logic [mlca_pkg::DVD_W-1:0]     quo_a;
  logic [mlca_pkg::DVD_W-1:0]     quo_b;
  logic [mlca_pkg::WQ_W+mlca_pkg::CNT_W-mlca_pkg::FRAC_W-1:0] prod;
  logic [mlca_pkg::DVD_W-1:0]     dvd_a;
  logic [mlca_pkg::DVD_W-1:0]     dvd_b;
  logic [mlca_pkg::DVD_W-1:0]     wq_head;
  logic [mlca_pkg::DVD_W-1:0]     wq_cmd;
  logic [mlca_pkg::IDX_W-1:0]     row_idx;
  logic                           row_touched;
  logic                           rd_in_range;
  logic [ROW_W-1:0]               rd_row;
  logic [ROW_W-1:0]               rd_col;

  // Scaled weights and divider operands
  assign prod    = head_cmd.weight * head_cmd.gt_cnt;
  assign dvd_a   = {prod, {mlca_pkg::FRAC_W{1'b0}}};
  assign wq_head = mlca_pkg::DVD_W'({head_cmd.weight, {mlca_pkg::FRAC_W{1'b0}}});
  assign wq_cmd  = mlca_pkg::DVD_W'({cmd_r.weight, {mlca_pkg::FRAC_W{1'b0}}});
  assign dvd_b   = wq_head;

  assign div_start = (state_r == S_IDLE) && q_valid &&
                     head_cmd.op == mlca_pkg::OP_ACC && head_cmd.need_div;

  mlca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd_a (dvd_a),
    .dvd_b (dvd_b),
    .dvs   (head_cmd.divisor),
    .done  (div_done),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  assign row_idx     = mlca_pkg::IDX_W'(row_r);
  assign row_touched = cmd_r.diag_rows[row_idx] | cmd_r.blk_rows[row_idx];
  assign rd_in_range = (int'(cmd_r.row) < MAX_CLASSES) && (int'(cmd_r.col) < MAX_CLASSES);
  assign rd_row      = cmd_r.row[ROW_W-1:0];
  assign rd_col      = cmd_r.col[ROW_W-1:0];

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign mem_re    = (state_r == S_RD);
  assign mem_raddr = (cmd_r.op == mlca_pkg::OP_READ) ? rd_row : row_r;
  assign mem_we    = (state_r == S_WR);

  // Add one term per entry of the row, saturating
  always_comb begin
    logic [mlca_pkg::ENTRY_W-1:0] old_v;
    logic [mlca_pkg::ENTRY_W-1:0] add_v;
    logic [mlca_pkg::ENTRY_W:0]   sum_v;
    for (int j = 0; j < NCE; j++) begin
      old_v = rvalid_r ? rdata_r[j] : '0;
      if (cmd_r.diag_rows[row_idx] && j == int'(row_r)) begin
        add_v = mlca_pkg::ENTRY_W'(damt_r);
      end else if (cmd_r.blk_rows[row_idx] && cmd_r.blk_cols[j]) begin
        add_v = mlca_pkg::ENTRY_W'(bamt_r);
      end else begin
        add_v = '0;
      end
      sum_v    = {1'b0, old_v} + {1'b0, add_v};
      wdata[j] = sum_v[mlca_pkg::ENTRY_W] ? '1 : sum_v[mlca_pkg::ENTRY_W-1:0];
    end
  end

  // Row store: registered read, one row write
  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
    if (mem_we) begin
      mem[row_r] <= wdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_valid_r <= '0;
      out_valid_r <= 1'b0;
      row_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r  <= head_cmd;
            row_r  <= '0;
            damt_r <= wq_head;
            bamt_r <= '0;
            unique case (head_cmd.op)
              mlca_pkg::OP_CLEAR: row_valid_r <= '0;
              mlca_pkg::OP_READ:  state_r <= S_RD;
              mlca_pkg::OP_ACC:   state_r <= head_cmd.need_div ? S_DIV : S_RD;
              default:            state_r <= S_IDLE;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            damt_r  <= cmd_r.diag_div ? quo_a : wq_cmd;
            bamt_r  <= quo_b;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (cmd_r.op == mlca_pkg::OP_READ) begin
            rvalid_r   <= row_valid_r[rd_row];
            in_range_r <= rd_in_range;
            state_r    <= S_OUT;
          end else if (row_touched) begin
            rvalid_r <= row_valid_r[row_r];
            state_r  <= S_WR;
          end else if (row_r == ROW_W'(NCE - 1)) begin
            state_r <= S_IDLE;
          end else begin
            row_r <= row_r + 1'b1;
          end
        end
        S_WR: begin
          row_valid_r[row_r] <= 1'b1;
          if (row_r == ROW_W'(NCE - 1)) begin
            state_r <= S_IDLE;
          end else begin
            row_r   <= row_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_value_r <= (in_range_r && rvalid_r) ? rdata_r[rd_col] : '0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_entry_value = out_value_r;
  assign stat.active     = (state_r != S_IDLE);
  assign stat.div_wait   = (state_r == S_DIV);

endmodule

/* rtl/core/multilabel_confusion_accumulate.sv */
// ----------------------------------------------------------------------------
// multilabel_confusion_accumulate
// Multi-label confusion matrix accumulator with command-style input.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy rises only
// when the two-entry command queue is full. Results (reads only) appear on
// out_entry_value for one cycle with out_valid and cannot be held off. An
// accumulate is dequeued, runs through the bit-serial divider when the case
// divides by a predicted-class count, then sweeps the matrix rows: an
// untouched row is only checked, a touched row is read and then written.
// The divider and the row sweep of the single-port row store dominate its
// cost. A read passes through the row-read and output states, and its result
// is registered in the output state; a clear marks all rows invalid at once,
// with no clearing pass. Entries are unsigned Q40.16, saturating at 2^56-1.
// ----------------------------------------------------------------------------
`include "multilabel_confusion_accumulate_assert.svh"

module multilabel_confusion_accumulate #(
  parameter int MAX_CLASSES = mlca_pkg::MAX_CLASSES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mlca_pkg::PADDR_W-1:0]      paddr,
  input  logic [mlca_pkg::PDATA_W-1:0]      pwdata,
  output logic [mlca_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [mlca_pkg::FUNC_W-1:0]       in_func,
  input  logic [mlca_pkg::MASK_W-1:0]       in_gt_mask,
  input  logic [mlca_pkg::MASK_W-1:0]       in_pred_mask,
  input  logic [mlca_pkg::WEIGHT_W-1:0]     in_weight,
  input  logic [mlca_pkg::IDX_W-1:0]        in_row_index,
  input  logic [mlca_pkg::IDX_W-1:0]        in_col_index,
  output logic                              out_valid,
  output logic [mlca_pkg::ENTRY_W-1:0]      out_entry_value
);

  logic                            accept;
  logic                            q_push;
  logic                            q_pop;
  logic                            q_valid;
  logic                            q_full;
  logic [mlca_pkg::QCNT_W-1:0]     q_count;
  mlca_pkg::cmd_t                  front_cmd;
  mlca_pkg::cmd_t                  head_cmd;
  mlca_pkg::back_stat_t            back_stat;

  assign busy   = q_full;
  assign accept = start && !busy;

  mlca_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .accept       (accept),
    .in_func      (in_func),
    .in_gt_mask   (in_gt_mask),
    .in_pred_mask (in_pred_mask),
    .in_weight    (in_weight),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .cmd_valid    (q_push),
    .cmd          (front_cmd)
  );

  mlca_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (front_cmd),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .head_cmd (head_cmd),
    .full     (q_full),
    .count    (q_count)
  );

  mlca_back #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .head_cmd        (head_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_entry_value (out_entry_value),
    .stat            (back_stat)
  );

  // A pushed command is either queued or already being executed
  `MLCA_ASSERT_NEXT(a_push_held, q_push, (q_count != '0) || back_stat.active, "command lost")
  // Read results never come in consecutive cycles
  `MLCA_ASSERT_NEXT(a_out_single, out_valid, !out_valid, "back-to-back result")
  // The back only dequeues while it is not executing
  `MLCA_ASSERT_SAME(a_pop_idle, q_pop, !back_stat.active && !back_stat.div_wait, "pop while busy")

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// Confusion accumulator testbench
// Drives accumulate, read and clear commands through the start/busy port and
// checks every read against a behavioral matrix predictor or a typed value. The
// active class count is changed over APB between phases, covering both extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mlca_pkg::*;

  localparam int NCLS = MAX_CLASSES_DEF;
  localparam logic [ENTRY_W-1:0] SAT = {ENTRY_W{1'b1}};
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // worst case in flight: two queued and one executing accumulate, each
  // with the divider and a full row sweep
  localparam int DRAIN_CYC = 3 * (47 + 2 * NCLS) + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [FUNC_W-1:0] in_func = '0;
  logic [MASK_W-1:0] in_gt_mask = '0, in_pred_mask = '0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic [IDX_W-1:0] in_row_index = '0, in_col_index = '0;
  logic out_valid;
  logic [ENTRY_W-1:0] out_entry_value;

  multilabel_confusion_accumulate dut (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .in_func(in_func), .in_gt_mask(in_gt_mask),
    .in_pred_mask(in_pred_mask), .in_weight(in_weight),
    .in_row_index(in_row_index), .in_col_index(in_col_index),
    .out_valid(out_valid), .out_entry_value(out_entry_value)
  );

  always #6 clk = ~clk;

  typedef struct {
    logic [FUNC_W-1:0]   func;
    logic [MASK_W-1:0]   gt;
    logic [MASK_W-1:0]   pred;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    row;
    logic [IDX_W-1:0]    col;
    bit                  fixed;   // expected value typed in the row
    logic [ENTRY_W-1:0]  value;
  } cmd_row_t;

  // predictor state
  logic [ENTRY_W-1:0] matrix [NCLS][NCLS];
  logic [ACLS_W-1:0]  class_count = ACTIVE_CLASSES_RST;
  logic [ENTRY_W-1:0] pending_reads [$];
  int errors = 0;

  task automatic report_mismatch(input string what, input logic [ENTRY_W-1:0] got,
                                 input logic [ENTRY_W-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int ones(input logic [MASK_W-1:0] m);
    int n = 0;
    for (int k = 0; k < MASK_W; k++) n += m[k];
    return n;
  endfunction

  function automatic void add_cell(input int r, input int c, input logic [63:0] amt);
    logic [63:0] sum;
    sum = {8'b0, matrix[r][c]} + amt;
    matrix[r][c] = (sum > {8'b0, SAT}) ? SAT : sum[ENTRY_W-1:0];
  endfunction

  function automatic void add_area(input logic [MASK_W-1:0] rows,
                                   input logic [MASK_W-1:0] cols, input int nc,
                                   input logic [63:0] amt);
    for (int i = 0; i < nc; i++)
      if (rows[i])
        for (int j = 0; j < nc; j++)
          if (cols[j]) add_cell(i, j, amt);
  endfunction

  function automatic void accumulate_pair(input logic [MASK_W-1:0] gm,
                                          input logic [MASK_W-1:0] pm,
                                          input logic [WEIGHT_W-1:0] w);
    int nc;
    logic [MASK_W-1:0] keep, g, p, pd;
    logic [63:0] wq;
    int dp;
    nc = (class_count > NCLS) ? NCLS : int'(class_count);
    keep = (nc >= MASK_W) ? '1 : MASK_W'((32'd1 << nc) - 1);
    g = gm & keep;
    p = pm & keep;
    wq = {24'b0, w, 16'b0};
    if (g == p) begin
      add_area(g & ~p | g, '0, nc, 0);
      for (int k = 0; k < nc; k++) if (g[k]) add_cell(k, k, wq);
    end else if ((g & p) == g) begin
      dp = ones(p);
      for (int k = 0; k < nc; k++) if (g[k]) add_cell(k, k, wq * ones(g) / dp);
      add_area(g, p & ~g, nc, wq / dp);
    end else if ((g | p) == g) begin
      dp = ones(p);
      for (int k = 0; k < nc; k++) if (p[k]) add_cell(k, k, wq);
      if (dp != 0) add_area(g & ~p, p, nc, wq / dp);
    end else begin
      pd = p & ~g;
      dp = ones(pd);
      for (int k = 0; k < nc; k++) if (g[k] && p[k]) add_cell(k, k, wq);
      if (dp != 0) add_area(g & ~p, pd, nc, wq / dp);
    end
  endfunction

  // Update the predictor for one accepted transaction
  function automatic void predict(input cmd_row_t c);
    case (c.func)
      FUNC_ACC: accumulate_pair(c.gt, c.pred, c.weight);
      FUNC_READ: begin
        if (c.fixed && c.value !== matrix[c.row][c.col])
          $display("note: typed value differs from prediction");
        pending_reads = {pending_reads, (c.fixed ? c.value : matrix[c.row][c.col])};
      end
      FUNC_CLEAR: foreach (matrix[i, j]) matrix[i][j] = '0;
      default: ;
    endcase
  endfunction

  // Check read results against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_reads.size() == 0)
        report_mismatch("unexpected entry_value", out_entry_value, '0);
      else if (out_entry_value !== pending_reads[0]) begin
        report_mismatch("entry_value", out_entry_value, pending_reads[0]);
        void'(pending_reads.pop_front());
      end else
        void'(pending_reads.pop_front());
    end
  end

  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  // Send one transaction, hold start until it is taken; start stays high
  // afterwards so that a transaction with no gap follows back to back
  task automatic issue(input cmd_row_t c, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      idle_cycles(gap);
    end
    start <= 1'b1;
    in_func <= c.func;
    in_gt_mask <= c.gt;
    in_pred_mask <= c.pred;
    in_weight <= c.weight;
    in_row_index <= c.row;
    in_col_index <= c.col;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(c);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    idle_cycles(DRAIN_CYC);
  endtask

  task automatic write_classes(input logic [ACLS_W-1:0] n);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= REG_ACTIVE_CLASSES;
    pwdata <= PDATA_W'(n);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    class_count = n;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic cmd_row_t mk(input logic [FUNC_W-1:0] f, input logic [MASK_W-1:0] g,
                                  input logic [MASK_W-1:0] p, input logic [WEIGHT_W-1:0] w,
                                  input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c,
                                  input bit fx = 0, input logic [ENTRY_W-1:0] v = '0);
    cmd_row_t x;
    x.func = f; x.gt = g; x.pred = p; x.weight = w;
    x.row = r; x.col = c; x.fixed = fx; x.value = v;
    return x;
  endfunction

  function automatic logic [MASK_W-1:0] rand_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = MASK_W'($urandom);
      1: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      2: m = MASK_W'($urandom) & MASK_W'($urandom);
      default: m = MASK_W'($urandom) & 16'h000f;
    endcase
    return m;
  endfunction

  // Random transaction: mostly accumulates of related mask pairs
  function automatic cmd_row_t rand_cmd();
    logic [MASK_W-1:0] g, p;
    logic [WEIGHT_W-1:0] w;
    int sel;
    g = rand_mask();
    case ($urandom_range(0, 4))
      0: p = g;
      1: p = g | rand_mask();
      2: p = g & rand_mask();
      default: p = rand_mask();
    endcase
    w = ($urandom_range(0, 9) == 0) ? WEIGHT_W'($urandom) : WEIGHT_W'($urandom_range(0, 4000));
    sel = $urandom_range(0, 99);
    if (sel < 60) return mk(FUNC_ACC, g, p, w, IDX_W'($urandom), IDX_W'($urandom));
    if (sel < 95) return mk(FUNC_READ, g, p, w, IDX_W'($urandom), IDX_W'($urandom));
    if (sel < 97) return mk(FUNC_CLEAR, g, p, w, IDX_W'($urandom), IDX_W'($urandom));
    return mk(FUNC_UNUSED, g, p, w, IDX_W'($urandom), IDX_W'($urandom));
  endfunction

  cmd_row_t directed [$];
  logic [ACLS_W-1:0] phase_counts [5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5};

  initial begin
    foreach (matrix[i, j]) matrix[i][j] = '0;
    // Directed table
    directed = {
      mk(FUNC_READ, 0, 0, 0, 0, 0, 1, '0),                 // after reset
      mk(FUNC_READ, 0, 0, 0, 15, 15, 1, '0),
      mk(FUNC_ACC, 16'h0003, 16'h0003, 24'hffffff, 0, 0),  // equal masks
      mk(FUNC_READ, 0, 0, 0, 1, 1, 1, {16'b0, 24'hffffff, 16'b0}),
      mk(FUNC_ACC, 16'h0001, 16'h0007, 24'd3, 0, 0),       // superset
      mk(FUNC_READ, 0, 0, 0, 0, 0),
      mk(FUNC_READ, 0, 0, 0, 0, 2),
      mk(FUNC_ACC, 16'hf000, 16'h1000, 24'd7, 0, 0),       // subset
      mk(FUNC_READ, 0, 0, 0, 13, 12),
      mk(FUNC_ACC, 16'h00ff, 16'h0000, 24'd9, 0, 0),       // empty prediction
      mk(FUNC_ACC, 16'h0000, 16'hffff, 24'd1, 0, 0),
      mk(FUNC_ACC, 16'h0a0a, 16'h0505, 24'd11, 0, 0),      // disjoint
      mk(FUNC_ACC, 16'h0a0f, 16'h05f5, 24'd5, 0, 0),
      mk(FUNC_READ, 0, 0, 0, 1, 0),
      mk(FUNC_READ, 0, 0, 0, 3, 15),
      mk(FUNC_UNUSED, 16'hffff, 16'hffff, 24'hffffff, 15, 15),
      mk(FUNC_CLEAR, 0, 0, 0, 0, 0),
      mk(FUNC_READ, 0, 0, 0, 1, 1, 1, '0)
    };
    for (int k = 0; k < 40; k++)  // pile the largest weight onto one diagonal entry
      directed = {directed, mk(FUNC_ACC, 16'h8000, 16'h8000, 24'hffffff, 0, 0)};
    directed = {directed, mk(FUNC_READ, 0, 0, 0, 15, 15, 1, 56'h00_27ff_ffd8_0000)};

    idle_cycles(11);
    rst_n <= 1'b1;
    idle_cycles(2);
    foreach (directed[k]) issue(directed[k], (k % 3 == 0) ? 0 : $urandom_range(0, 18));

    // Random phases across class counts
    foreach (phase_counts[ph]) begin
      write_classes(phase_counts[ph]);
      for (int k = 0; k < 108; k++)
        issue(rand_cmd(), ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0);
    end
    drain();
    if (errors == 0 && pending_reads.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("status: fail");
    $finish;
  end
endmodule
